[sv/seven_bit_packet_framer_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seven-bit packet framer
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEVEN_BIT_PACKET_FRAMER_TOP_DEFINES_SVH
`define SEVEN_BIT_PACKET_FRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SBPF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbpf assertion failed");
// next-cycle implication
`define SBPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbpf assertion failed");
`else
`define SBPF_ASSERT_IMPL(label, ante, cons)
`define SBPF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/sbpf_pkg.sv]
// ----------------------------------------------------------------------------
// sbpf_pkg
// Types, line codes and helpers shared by the seven-bit packet framer.
// ----------------------------------------------------------------------------
package sbpf_pkg;

    // request queue depth between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // register write command length in bytes
    localparam int unsigned CMD_BYTES = 8;

    // line codes
    localparam logic [7:0] LINE_START = 8'h00;
    localparam logic [7:0] LINE_END   = 8'h02;

    // register write command bytes
    localparam logic [7:0] CMD_HDR0   = 8'h42;
    localparam logic [7:0] CMD_HDR1   = 8'h12;
    localparam logic [7:0] BANK0_SEL  = 8'hE1;
    localparam logic [7:0] BANK1_SEL  = 8'hE5;
    localparam logic [7:0] BANK0_DATA = 8'hE3;
    localparam logic [7:0] BANK1_DATA = 8'hE7;
    localparam logic [7:0] CMD_MID    = 8'hFB;

    // request classes
    typedef enum logic [1:0] {
        K_RAW,
        K_RAW_LAST,
        K_REG
    } t_kind;

    // classified request
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       bank;
        logic [7:0] idx;
        logic [7:0] val;
    } t_item;

    // back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_GROUP,
        S_CPAD,
        S_CEND
    } t_state;

    // byte bi of the payload stream of a request
    function automatic logic [7:0] cmd_byte(t_item it, logic [2:0] bi);
        logic [7:0] b;
        b = it.data;
        if (it.kind == K_REG) begin
            unique case (bi)
                3'd0: b = CMD_HDR0;
                3'd1: b = CMD_HDR1;
                3'd2: b = it.bank ? BANK1_SEL : BANK0_SEL;
                3'd3: b = it.idx;
                3'd4: b = it.bank ? BANK1_DATA : BANK0_DATA;
                3'd5: b = it.val;
                3'd6: b = CMD_MID;
                3'd7: b = it.val;
                default: b = it.data;
            endcase
        end
        return b;
    endfunction

    // top 7 of cnt held bits (cnt is 7..14) as a line byte
    function automatic logic [7:0] take_group(logic [13:0] w, logic [3:0] cnt);
        logic [13:0] t;
        t = w >> (cnt - 4'd7);
        return {t[6:0], 1'b1};
    endfunction

    // last cnt bits (cnt is 1..6) zero-padded on the right as a line byte
    function automatic logic [7:0] pad_group(logic [13:0] w, logic [3:0] cnt);
        logic [13:0] t;
        t = w << (4'd7 - cnt);
        return {t[6:0], 1'b1};
    endfunction

endpackage

[sv/sbpf_in_if.sv]
// ----------------------------------------------------------------------------
// sbpf_in_if
// Request channel of the framer: one raw byte or one register write.
// ----------------------------------------------------------------------------
interface sbpf_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [8:0] reg_index;
    logic [7:0] reg_value;

    modport source (
        output valid, func, data_byte, last_byte, reg_index, reg_value,
        input  ready
    );
    modport sink (
        input  valid, func, data_byte, last_byte, reg_index, reg_value,
        output ready
    );
endinterface

[sv/sbpf_out_if.sv]
// ----------------------------------------------------------------------------
// sbpf_out_if
// Line byte channel of the framer.
// ----------------------------------------------------------------------------
interface sbpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (
        output valid, out_byte, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_run,
        output ready
    );
endinterface

[sv/seven_bit_packet_framer_top.sv]
// ----------------------------------------------------------------------------
// seven_bit_packet_framer_top
// Serial link framer: packs bytes into 7-bit groups with start/end codes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests: func 0 frames one raw byte (last_byte closes the
//   packet), func 1 frames a complete register write command.
//   o_out carries line bytes; last_of_run marks the final byte of a request.
//   Both channels move a request when valid and ready are high at a clock edge.
// Path: from an idle block, the first line byte of a request passes the front
//   stage and queue write, the sequencer pick-up, then the output register.
// Throughput: the back sequencer emits one line byte per cycle while o_out is
//   not held off; the front keeps taking requests while the queue has room.
// Reset: synchronous on i_rst_n low; no packet is open and the queue is empty.
// Stall: while o_out is held off the sequencer stops, the queue fills and
//   i_in.ready drops once queue and front stage are full; nothing is lost.
// ----------------------------------------------------------------------------
module seven_bit_packet_framer_top #(
    parameter int unsigned QUEUE_DEPTH = sbpf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbpf_in_if.sink     i_in,
    sbpf_out_if.source  o_out
);

    logic            f_valid;
    sbpf_pkg::t_item f_item;
    logic            q_ready;
    logic            q_valid;
    sbpf_pkg::t_item q_item;
    logic            q_pop;

    // classify requests
    sbpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_ready (q_ready)
    );

    // request queue
    sbpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // line byte sequencer
    sbpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

[sv/sbpf_front.sv]
// ----------------------------------------------------------------------------
// sbpf_front
// Accepts requests, classifies them and registers the result for the queue.
// ----------------------------------------------------------------------------
module sbpf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbpf_in_if.sink           i_in,
    output logic              o_valid,
    output sbpf_pkg::t_item   o_item,
    input  logic              i_ready
);

    logic            r_valid;
    sbpf_pkg::t_item r_item;
    sbpf_pkg::t_item n_item;
    logic            take;

    assign i_in.ready = !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;

    // classify the request
    always_comb begin
        if (i_in.func) begin
            n_item.kind = sbpf_pkg::K_REG;
        end else if (i_in.last_byte) begin
            n_item.kind = sbpf_pkg::K_RAW_LAST;
        end else begin
            n_item.kind = sbpf_pkg::K_RAW;
        end
        n_item.data = i_in.data_byte;
        n_item.bank = i_in.reg_index[8];
        n_item.idx  = i_in.reg_index[7:0];
        n_item.val  = i_in.reg_value;
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[sv/sbpf_queue.sv]
// ----------------------------------------------------------------------------
// sbpf_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module sbpf_queue #(
    parameter int unsigned DEPTH = sbpf_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sbpf_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_valid,
    output sbpf_pkg::t_item   o_item,
    input  logic              i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sbpf_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // entry write
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/sbpf_back.sv]
// ----------------------------------------------------------------------------
// sbpf_back
// Sequencer: queued requests to line bytes, one per cycle unless o_out stalls.
// ----------------------------------------------------------------------------
`include "seven_bit_packet_framer_top_defines.svh"

module sbpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  sbpf_pkg::t_item   i_q_item,
    output logic              o_q_pop,
    sbpf_out_if.source        o_out
);

    sbpf_pkg::t_state r_state, n_state;
    logic [13:0]      r_w, n_w;      // pending bits, newest low
    logic [3:0]       r_cnt, n_cnt;  // number of pending bits
    logic             r_open, n_open;
    logic             r_fin, n_fin;  // closing phase of a request
    logic [2:0]       r_bi, n_bi;    // payload byte index
    sbpf_pkg::t_item  r_item, n_item;

    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast;

    logic             out_free;
    logic             adv;
    logic [7:0]       e_byte;
    logic             e_last;
    logic [3:0]       rem_cnt;
    logic             bytes_done;

    assign out_free   = !r_ovalid || o_out.ready;
    assign adv        = (r_state != sbpf_pkg::S_IDLE) && out_free;
    assign rem_cnt    = r_cnt - 4'd7;
    assign bytes_done = (r_item.kind != sbpf_pkg::K_REG)
                     || (r_bi == 3'(sbpf_pkg::CMD_BYTES - 1));

    // line byte for the current state
    always_comb begin
        e_byte = sbpf_pkg::LINE_START;
        e_last = 1'b0;
        unique case (r_state)
            sbpf_pkg::S_IDLE: begin
                e_byte = sbpf_pkg::LINE_START;
            end
            sbpf_pkg::S_OPEN: begin
                e_byte = sbpf_pkg::LINE_START;
            end
            sbpf_pkg::S_GROUP: begin
                e_byte = sbpf_pkg::take_group(r_w, r_cnt);
                e_last = (r_cnt < 4'd14) && bytes_done && (r_item.kind == sbpf_pkg::K_RAW);
            end
            sbpf_pkg::S_CPAD: begin
                e_byte = sbpf_pkg::pad_group(r_w, r_cnt);
            end
            sbpf_pkg::S_CEND: begin
                e_byte = sbpf_pkg::LINE_END;
                e_last = r_fin;
            end
            default: begin
                e_byte = sbpf_pkg::LINE_START;
            end
        endcase
    end

    // next state, then start of the next request when this one is done
    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        n_cnt   = r_cnt;
        n_open  = r_open;
        n_fin   = r_fin;
        n_bi    = r_bi;
        n_item  = r_item;
        o_q_pop = 1'b0;

        if (adv) begin
            unique case (r_state)
                sbpf_pkg::S_OPEN: begin
                    n_open  = 1'b1;
                    n_bi    = 3'd0;
                    n_w     = {r_w[5:0], sbpf_pkg::cmd_byte(r_item, 3'd0)};
                    n_cnt   = 4'd8;
                    n_state = sbpf_pkg::S_GROUP;
                end
                sbpf_pkg::S_GROUP: begin
                    n_cnt = rem_cnt;
                    if (rem_cnt >= 4'd7) begin
                        n_state = sbpf_pkg::S_GROUP;
                    end else if (!bytes_done) begin
                        n_bi  = r_bi + 3'd1;
                        n_w   = {r_w[5:0], sbpf_pkg::cmd_byte(r_item, r_bi + 3'd1)};
                        n_cnt = rem_cnt + 4'd8;
                    end else if (r_item.kind != sbpf_pkg::K_RAW) begin
                        n_fin   = 1'b1;
                        n_state = (rem_cnt != 4'd0) ? sbpf_pkg::S_CPAD : sbpf_pkg::S_CEND;
                    end
                end
                sbpf_pkg::S_CPAD: begin
                    n_cnt   = 4'd0;
                    n_state = sbpf_pkg::S_CEND;
                end
                sbpf_pkg::S_CEND: begin
                    n_open  = 1'b0;
                    n_cnt   = 4'd0;
                    n_state = sbpf_pkg::S_OPEN;
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end

        // pick up the next request with no bubble
        if ((r_state == sbpf_pkg::S_IDLE) || (adv && e_last)) begin
            if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_item  = i_q_item;
                n_fin   = 1'b0;
                n_bi    = 3'd0;
                if (i_q_item.kind == sbpf_pkg::K_REG) begin
                    if (n_open) begin
                        n_state = (n_cnt != 4'd0) ? sbpf_pkg::S_CPAD : sbpf_pkg::S_CEND;
                    end else begin
                        n_state = sbpf_pkg::S_OPEN;
                    end
                end else if (!n_open) begin
                    n_state = sbpf_pkg::S_OPEN;
                end else begin
                    n_w     = {n_w[5:0], i_q_item.data};
                    n_cnt   = n_cnt + 4'd8;
                    n_state = sbpf_pkg::S_GROUP;
                end
            end else begin
                n_state = sbpf_pkg::S_IDLE;
            end
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbpf_pkg::S_IDLE;
            r_cnt   <= 4'd0;
            r_open  <= 1'b0;
            r_fin   <= 1'b0;
            r_bi    <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_open  <= n_open;
            r_fin   <= n_fin;
            r_bi    <= n_bi;
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_item <= n_item;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte <= e_byte;
            r_olast <= e_last;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_byte    = r_obyte;
    assign o_out.last_of_run = r_olast;

    // checks
    `SBPF_ASSERT_IMPL(a_idle_cnt, r_state == sbpf_pkg::S_IDLE, r_cnt < 4'd7)
    `SBPF_ASSERT_IMPL(a_group_cnt, r_state == sbpf_pkg::S_GROUP, r_cnt >= 4'd7)
    `SBPF_ASSERT_IMPL(a_pad_open, r_state == sbpf_pkg::S_CPAD, r_open && r_cnt != 4'd0 && r_cnt < 4'd7)
    `SBPF_ASSERT_NEXT(a_open_group, adv && r_state == sbpf_pkg::S_OPEN, r_state == sbpf_pkg::S_GROUP && r_open)

endmodule
